// ----- hdl/tcc_pkg.sv -----
`default_nettype none
package tcc_pkg;

  // field widths
  localparam int CoordW  = 32;
  localparam int TrackW  = 16;
  localparam int TimeW   = 32;
  localparam int RadW    = 20;

  // internal widths
  localparam int DiffW   = CoordW + 1;        // coordinate difference and sum
  localparam int MagW    = RadW + 2;          // |dx|, |dy| once within two radii
  localparam int SqW     = 2 * MagW - 1;      // square of a magnitude
  localparam int SumSqW  = SqW + 1;           // dx^2 + dy^2
  localparam int R2W     = 2 * RadW;          // radius^2
  localparam int R4W     = R2W + 2;           // 4 * radius^2
  localparam int FracSh  = 16;                // pre-shift ahead of the roots
  localparam int SqrtInW = R4W + FracSh;      // root operand
  localparam int RootW   = SqrtInW / 2;       // root result
  localparam int NumW    = MagW + RootW;      // offset numerator
  localparam int QuoW    = 23;                // offset magnitude, Q.8
  localparam int OffW    = QuoW + 2;          // signed offset
  localparam int CtrW    = DiffW + 2;         // sum plus offset

  // configuration register indexes
  localparam int CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIUS     = 1'b0,
    REG_PAPER_MODE = 1'b1
  } cfg_reg_t;

  // sideband that travels with each item
  typedef struct packed {
    logic                     ok;
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     paper;
    logic signed [DiffW-1:0]  sum_x;
    logic signed [DiffW-1:0]  sum_y;
    logic [MagW-1:0]          adx;
    logic [MagW-1:0]          ady;
    logic [TimeW-1:0]         ts;
    logic [TrackW-1:0]        track_a;
    logic [TrackW-1:0]        track_b;
  } side_t;

endpackage
`default_nettype wire

// ----- hdl/tcc_in_if.sv -----
`default_nettype none
interface tcc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tcc_pkg::CoordW-1:0]    first_x;
  logic signed [tcc_pkg::CoordW-1:0]    first_y;
  logic [tcc_pkg::TrackW-1:0]           first_track;
  logic signed [tcc_pkg::CoordW-1:0]    second_x;
  logic signed [tcc_pkg::CoordW-1:0]    second_y;
  logic [tcc_pkg::TrackW-1:0]           second_track;
  logic [tcc_pkg::TimeW-1:0]            time_stamp;

  modport source (output valid, first_x, first_y, first_track, second_x, second_y,
                  second_track, time_stamp, input ready);
  modport sink (input valid, first_x, first_y, first_track, second_x, second_y,
                second_track, time_stamp, output ready);
endinterface
`default_nettype wire

// ----- hdl/tcc_out_if.sv -----
`default_nettype none
interface tcc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 disks_found;
  logic signed [tcc_pkg::CoordW-1:0]    center_one_x;
  logic signed [tcc_pkg::CoordW-1:0]    center_one_y;
  logic signed [tcc_pkg::CoordW-1:0]    center_two_x;
  logic signed [tcc_pkg::CoordW-1:0]    center_two_y;
  logic [tcc_pkg::TimeW-1:0]            out_time_stamp;
  logic [tcc_pkg::TrackW-1:0]           out_first_track;
  logic [tcc_pkg::TrackW-1:0]           out_second_track;

  modport source (output valid, disks_found, center_one_x, center_one_y, center_two_x,
                  center_two_y, out_time_stamp, out_first_track, out_second_track,
                  input ready);
  modport sink (input valid, disks_found, center_one_x, center_one_y, center_two_x,
                center_two_y, out_time_stamp, out_first_track, out_second_track,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/tcc_cfg_if.sv -----
`default_nettype none
interface tcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcc_pkg::CfgIdxW-1:0]    addr;
  logic [tcc_pkg::RadW-1:0]       data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/tcc_isqrt.sv -----
`default_nettype none
// floor square root, one result bit per stage
module tcc_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [tcc_pkg::SqrtInW-1:0]   op,
  output logic      [tcc_pkg::RootW-1:0]     root
);
  localparam int W     = tcc_pkg::SqrtInW;
  localparam int Steps = tcc_pkg::RootW;

  logic [W-1:0] v_r   [Steps];
  logic [W-1:0] res_r [Steps];

  genvar k;
  for (k = 0; k < Steps; k++) begin : g_step
    localparam logic [W-1:0] Bit = W'(1) << (2 * (Steps - 1 - k));
    logic [W-1:0] v_i;
    logic [W-1:0] r_i;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      assign v_i = op;
      assign r_i = '0;
    end else begin : g_next
      assign v_i = v_r[k-1];
      assign r_i = res_r[k-1];
    end

    assign trial = r_i + Bit;

    // subtract the trial value where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_i >= trial) begin
          v_r[k]   <= v_i - trial;
          res_r[k] <= (r_i >> 1) + Bit;
        end else begin
          v_r[k]   <= v_i;
          res_r[k] <= r_i >> 1;
        end
      end
    end
  end

  assign root = res_r[Steps-1][tcc_pkg::RootW-1:0];
endmodule
`default_nettype wire

// ----- hdl/tcc_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per stage; quotient known to fit QuoW
module tcc_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [tcc_pkg::NumW-1:0]     num,
  input  wire logic [tcc_pkg::RootW-1:0]    den,
  output logic      [tcc_pkg::QuoW-1:0]     quo
);
  localparam int W     = tcc_pkg::NumW + 1;
  localparam int Steps = tcc_pkg::QuoW;

  logic [W-1:0]                 rem_r [Steps];
  logic [tcc_pkg::RootW-1:0]    den_r [Steps];
  logic [Steps-1:0]             q_r   [Steps];

  genvar s;
  for (s = 0; s < Steps; s++) begin : g_step
    logic [W-1:0]                rem_i;
    logic [tcc_pkg::RootW-1:0]   den_i;
    logic [Steps-1:0]            q_i;
    logic [W-1:0]                shifted;

    if (s == 0) begin : g_first
      assign rem_i = W'(num);
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign den_i = den_r[s-1];
      assign q_i   = q_r[s-1];
    end

    assign shifted = W'(den_i) << (Steps - 1 - s);

    // trial subtract of the shifted divisor
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_i;
        if (rem_i >= shifted) begin
          rem_r[s] <= rem_i - shifted;
          q_r[s]   <= q_i | (Steps'(1) << (Steps - 1 - s));
        end else begin
          rem_r[s] <= rem_i;
          q_r[s]   <= q_i;
        end
      end
    end
  end

  assign quo = q_r[Steps-1];
endmodule
`default_nettype wire

// ----- hdl/two_point_circle_centers_core.sv -----
// two_point_circle_centers_core
// Takes a pair of Q.8 points and returns the two centers of the circles of
// the configured radius through both points, with the timestamp and track
// ids copied through. Every input transaction gives one output transaction.
// Channels: in_ch (valid/ready, point pair), out_ch (valid/ready, result),
// cfg_ch (valid/ready write of radius or paper_mode, always ready; write
// only while no transaction is in flight).
// Path from input acceptance to output valid: three setup
// stages, 29 stages of the two parallel square root units, one multiply
// stage, 23 stages of the two parallel dividers, and the output register.
// Throughput: one transaction per cycle while the receiver does not stall; all stages move together.
// Reset (rst_n low, synchronous) clears every valid bit and loads radius
// 1.0 m and paper_mode 0.
// When the receiver stalls with a result held, the whole pipeline holds and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module two_point_circle_centers_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch,
  tcc_cfg_if.sink    cfg_ch
);
  localparam int SqSteps  = tcc_pkg::RootW;
  localparam int DivSteps = tcc_pkg::QuoW;

  // configuration registers
  logic [tcc_pkg::RadW-1:0] radius_r;
  logic                     paper_mode_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= tcc_pkg::RadW'(256);
      paper_mode_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (tcc_pkg::cfg_reg_t'(cfg_ch.addr))
        tcc_pkg::REG_RADIUS:     radius_r     <= cfg_ch.data;
        tcc_pkg::REG_PAPER_MODE: paper_mode_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // global advance
  logic out_valid_r;
  logic en;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: ordering, differences, range checks
  logic signed [tcc_pkg::DiffW-1:0] ax, ay, bx, by, dx, dy;
  logic [tcc_pkg::DiffW-1:0]        adx_f, ady_f;
  logic [tcc_pkg::RadW:0]           twor;
  logic                             swap;
  tcc_pkg::side_t                   side_a_nxt, side_a_r;
  logic                             v_a_r;

  always_comb begin
    swap = paper_mode_r && !(in_ch.first_track < in_ch.second_track);
    ax = swap ? tcc_pkg::DiffW'(in_ch.second_x) : tcc_pkg::DiffW'(in_ch.first_x);
    ay = swap ? tcc_pkg::DiffW'(in_ch.second_y) : tcc_pkg::DiffW'(in_ch.first_y);
    bx = swap ? tcc_pkg::DiffW'(in_ch.first_x) : tcc_pkg::DiffW'(in_ch.second_x);
    by = swap ? tcc_pkg::DiffW'(in_ch.first_y) : tcc_pkg::DiffW'(in_ch.second_y);
    dx = bx - ax;
    dy = by - ay;
    adx_f = dx[tcc_pkg::DiffW-1] ? tcc_pkg::DiffW'(-dx) : tcc_pkg::DiffW'(dx);
    ady_f = dy[tcc_pkg::DiffW-1] ? tcc_pkg::DiffW'(-dy) : tcc_pkg::DiffW'(dy);
    twor  = {radius_r, 1'b0};
    side_a_nxt.ok = !(dx == '0 && dy == '0) && !(paper_mode_r && dy == '0)
                    && adx_f <= tcc_pkg::DiffW'(twor) && ady_f <= tcc_pkg::DiffW'(twor);
    side_a_nxt.dx_neg  = dx[tcc_pkg::DiffW-1];
    side_a_nxt.dy_neg  = dy[tcc_pkg::DiffW-1];
    side_a_nxt.paper   = paper_mode_r;
    side_a_nxt.sum_x   = ax + bx;
    side_a_nxt.sum_y   = ay + by;
    side_a_nxt.adx     = adx_f[tcc_pkg::MagW-1:0];
    side_a_nxt.ady     = ady_f[tcc_pkg::MagW-1:0];
    side_a_nxt.ts      = in_ch.time_stamp;
    side_a_nxt.track_a = in_ch.first_track;
    side_a_nxt.track_b = in_ch.second_track;
  end

  // stage b: squares
  logic [tcc_pkg::SqW-1:0] sqx_r, sqy_r;
  logic [tcc_pkg::R2W-1:0] r2_r;
  tcc_pkg::side_t          side_b_r;
  logic                    v_b_r;

  // stage c: distance test and root operands
  logic [tcc_pkg::SumSqW-1:0]  d2;
  logic [tcc_pkg::R4W-1:0]     r4;
  logic [tcc_pkg::SqrtInW-1:0] q_op_r, d_op_r;
  tcc_pkg::side_t              side_c_nxt, side_c_r;
  logic                        v_c_r;

  always_comb begin
    d2 = tcc_pkg::SumSqW'(sqx_r) + tcc_pkg::SumSqW'(sqy_r);
    r4 = {r2_r, 2'b00};
    side_c_nxt    = side_b_r;
    side_c_nxt.ok = side_b_r.ok && d2 <= tcc_pkg::SumSqW'(r4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r <= side_a_nxt;
      sqx_r    <= tcc_pkg::SqW'(side_a_r.adx * side_a_r.adx);
      sqy_r    <= tcc_pkg::SqW'(side_a_r.ady * side_a_r.ady);
      r2_r     <= radius_r * radius_r;
      side_b_r <= side_a_r;
      q_op_r   <= {r4 - d2[tcc_pkg::R4W-1:0], tcc_pkg::FracSh'(0)};
      d_op_r   <= {d2[tcc_pkg::R4W-1:0], tcc_pkg::FracSh'(0)};
      side_c_r <= side_c_nxt;
    end
  end

  // square roots of 4*r^2 - d^2 (twice the center-to-chord distance) and of d^2 (chord length)
  logic [tcc_pkg::RootW-1:0] hq, dl;

  tcc_isqrt u_sqrt_h (.clk(clk), .en(en), .op(q_op_r), .root(hq));
  tcc_isqrt u_sqrt_d (.clk(clk), .en(en), .op(d_op_r), .root(dl));

  tcc_pkg::side_t side_d_r [SqSteps];
  logic [SqSteps-1:0] v_d_r;

  // stage m: offset numerators
  logic [tcc_pkg::NumW-1:0]  numx_r, numy_r;
  logic [tcc_pkg::RootW-1:0] dl_m_r;
  tcc_pkg::side_t            side_m_r;
  logic                      v_m_r;

  logic [tcc_pkg::QuoW-1:0] magx, magy;

  tcc_div u_div_x (.clk(clk), .en(en), .num(numx_r), .den(dl_m_r), .quo(magx));
  tcc_div u_div_y (.clk(clk), .en(en), .num(numy_r), .den(dl_m_r), .quo(magy));

  tcc_pkg::side_t side_e_r [DivSteps];
  logic [DivSteps-1:0] v_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r[0] <= side_c_r;
      for (int i = 1; i < SqSteps; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
      numx_r   <= tcc_pkg::NumW'(side_d_r[SqSteps-1].ady * hq) + tcc_pkg::NumW'(dl >> 1);
      numy_r   <= tcc_pkg::NumW'(side_d_r[SqSteps-1].adx * hq) + tcc_pkg::NumW'(dl >> 1);
      dl_m_r   <= dl;
      side_m_r <= side_d_r[SqSteps-1];
      side_e_r[0] <= side_m_r;
      for (int i = 1; i < DivSteps; i++) begin
        side_e_r[i] <= side_e_r[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= '0;
      v_m_r <= 1'b0;
      v_e_r <= '0;
    end else if (en) begin
      v_a_r <= in_ch.valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= {v_d_r[SqSteps-2:0], v_c_r};
      v_m_r <= v_d_r[SqSteps-1];
      v_e_r <= {v_e_r[DivSteps-2:0], v_m_r};
    end
  end

  // final stage: signed offsets, halving with rounding, saturation
  function automatic logic [tcc_pkg::CoordW-1:0] half_sat(
    input logic signed [tcc_pkg::CtrW-1:0] s
  );
    logic signed [tcc_pkg::CtrW-1:0] h;
    h = (s + tcc_pkg::CtrW'(1)) >>> 1;
    if (h > tcc_pkg::CtrW'(32'sh7fffffff)) begin
      return 32'h7fffffff;
    end else if (h < -tcc_pkg::CtrW'(33'sh080000000)) begin
      return 32'h80000000;
    end
    return h[tcc_pkg::CoordW-1:0];
  endfunction

  tcc_pkg::side_t                   sf;
  logic signed [tcc_pkg::OffW-1:0]  offx, offy;
  logic signed [tcc_pkg::CtrW-1:0]  sxe, sye, oxe, oye;

  always_comb begin
    sf   = side_e_r[DivSteps-1];
    offx = sf.dy_neg ? -tcc_pkg::OffW'(magx) : tcc_pkg::OffW'(magx);
    offy = sf.dx_neg ? tcc_pkg::OffW'(magy) : -tcc_pkg::OffW'(magy);
    if (sf.paper && sf.dy_neg) begin
      offx = -offx;
      offy = -offy;
    end
    sxe = tcc_pkg::CtrW'(sf.sum_x);
    sye = tcc_pkg::CtrW'(sf.sum_y);
    oxe = tcc_pkg::CtrW'(offx);
    oye = tcc_pkg::CtrW'(offy);
  end

  // output register
  logic                              found_r;
  logic [tcc_pkg::CoordW-1:0]        c1x_r, c1y_r, c2x_r, c2y_r;
  logic [tcc_pkg::TimeW-1:0]         ts_r;
  logic [tcc_pkg::TrackW-1:0]        t1_r, t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_e_r[DivSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found_r <= sf.ok;
      c1x_r   <= sf.ok ? half_sat(sxe + oxe) : '0;
      c1y_r   <= sf.ok ? half_sat(sye + oye) : '0;
      c2x_r   <= sf.ok ? half_sat(sxe - oxe) : '0;
      c2y_r   <= sf.ok ? half_sat(sye - oye) : '0;
      ts_r    <= sf.ts;
      t1_r    <= sf.track_a;
      t2_r    <= sf.track_b;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.disks_found      = found_r;
  assign out_ch.center_one_x     = c1x_r;
  assign out_ch.center_one_y     = c1y_r;
  assign out_ch.center_two_x     = c2x_r;
  assign out_ch.center_two_y     = c2y_r;
  assign out_ch.out_time_stamp   = ts_r;
  assign out_ch.out_first_track  = t1_r;
  assign out_ch.out_second_track = t2_r;

  // a held result stalls the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // a result without disks carries zero centers
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.disks_found |->
      out_ch.center_one_x == '0 && out_ch.center_one_y == '0 &&
      out_ch.center_two_x == '0 && out_ch.center_two_y == '0)
    else $error("centers not cleared for no-disk result");

  // quadratic mode puts the larger x first
  a_paper_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.disks_found && paper_mode_r |->
      $signed(out_ch.center_one_x) >= $signed(out_ch.center_two_x))
    else $error("center order wrong in quadratic mode");

  // a stalled pipeline keeps its output item
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(c1x_r) && $stable(ts_r))
    else $error("output item changed during stall");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int PipeLat   = 57;
  localparam int DrainWait = PipeLat + 8;
  localparam int CycLimit  = 600000;
  localparam int NumRand   = 2000;
  localparam int NumPhase  = 8;

  typedef struct {
    logic signed [tcc_pkg::CoordW-1:0] ax;
    logic signed [tcc_pkg::CoordW-1:0] ay;
    logic [tcc_pkg::TrackW-1:0]        ta;
    logic signed [tcc_pkg::CoordW-1:0] bx;
    logic signed [tcc_pkg::CoordW-1:0] by;
    logic [tcc_pkg::TrackW-1:0]        tb;
    logic [tcc_pkg::TimeW-1:0]         ts;
  } pair_t;

  typedef struct {
    logic                              found;
    logic signed [tcc_pkg::CoordW-1:0] c1x;
    logic signed [tcc_pkg::CoordW-1:0] c1y;
    logic signed [tcc_pkg::CoordW-1:0] c2x;
    logic signed [tcc_pkg::CoordW-1:0] c2y;
    logic [tcc_pkg::TimeW-1:0]         ts;
    logic [tcc_pkg::TrackW-1:0]        ta;
    logic [tcc_pkg::TrackW-1:0]        tb;
  } disks_t;

  // how a directed row is checked
  typedef enum int {CHK_PREDICT, CHK_NONE, CHK_MIDPOINT} chk_t;

  typedef struct {
    logic                              mode;
    chk_t                              chk;
    logic signed [tcc_pkg::CoordW-1:0] ax;
    logic signed [tcc_pkg::CoordW-1:0] ay;
    logic [tcc_pkg::TrackW-1:0]        ta;
    logic signed [tcc_pkg::CoordW-1:0] bx;
    logic signed [tcc_pkg::CoordW-1:0] by;
    logic [tcc_pkg::TrackW-1:0]        tb;
    logic [tcc_pkg::TimeW-1:0]         ts;
    logic signed [tcc_pkg::CoordW-1:0] mx;
    logic signed [tcc_pkg::CoordW-1:0] my;
  } row_t;

  localparam int NumRows = 18;
  row_t dir_rows [NumRows] = '{
    '{0, CHK_NONE, 0, 0, 16'h0000, 0, 0, 16'hffff, 32'h0, 0, 0},
    '{0, CHK_NONE, 0, 0, 1, 1024, 0, 2, 32'hffffffff, 0, 0},
    '{0, CHK_NONE, 32'h80000000, 32'h80000000, 16'hffff, 32'h7fffffff, 32'h7fffffff,
      16'h0, 32'h12345678, 0, 0},
    '{0, CHK_MIDPOINT, 0, 0, 5, 512, 0, 6, 1, 256, 0},
    '{0, CHK_MIDPOINT, 0, 0, 5, 0, -512, 6, 2, 0, -256},
    '{0, CHK_PREDICT, 0, 0, 3, 256, 0, 4, 3, 0, 0},
    '{0, CHK_PREDICT, 0, 0, 3, 0, 256, 4, 4, 0, 0},
    '{0, CHK_PREDICT, -100, 37, 9, 50, -80, 8, 5, 0, 0},
    '{0, CHK_PREDICT, 10, 40, 1, 300, 40, 2, 6, 0, 0},
    '{0, CHK_PREDICT, 32'h7fffff00, 0, 1, 32'h7fffff00, 256, 2, 7, 0, 0},
    '{0, CHK_PREDICT, 32'h80000000, 10, 1, 32'h80000000, -200, 2, 8, 0, 0},
    '{1, CHK_NONE, 10, 40, 1, 300, 40, 2, 9, 0, 0},
    '{1, CHK_NONE, 7, 7, 3, 7, 7, 3, 10, 0, 0},
    '{1, CHK_PREDICT, 0, 0, 4, 100, 200, 4, 11, 0, 0},
    '{1, CHK_PREDICT, 0, 0, 9, 100, 200, 2, 12, 0, 0},
    '{1, CHK_PREDICT, 0, 0, 2, 100, -200, 9, 13, 0, 0},
    '{1, CHK_MIDPOINT, 0, 0, 1, 0, 512, 2, 14, 0, 256},
    '{1, CHK_PREDICT, 32'h7fffffff, 32'h80000000, 16'hffff, 32'h7ffffe00, 32'h80000100,
      16'h0, 15, 0, 0}
  };

  logic clk;
  logic rst_n;
  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();
  tcc_cfg_if cfg_ch ();

  two_point_circle_centers_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor copy of the registers
  logic [tcc_pkg::RadW-1:0] rad_q8;
  logic                     paper_sel;

  disks_t pending_disks [$];
  int     mismatches = 0;
  int     cycles = 0;
  int     idle_sel;  // 0 none, 1 sender idle, 2 receiver stalls, 3 both

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor((s + 1) / 2) clamped to 32 bits
  function automatic logic [tcc_pkg::CoordW-1:0] halve_sat(input longint s);
    longint h;
    h = (s + 1) >>> 1;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    return h[tcc_pkg::CoordW-1:0];
  endfunction

  function automatic disks_t predict_disks(input pair_t p);
    disks_t r;
    longint x1, y1, x2, y2, dx, dy, offx, offy, sx, sy;
    logic [63:0] adx, ady, twor, d2, r4, hq, dl, magx, magy;
    x1 = p.ax; y1 = p.ay; x2 = p.bx; y2 = p.by;
    r = '{default: '0};
    r.ts = p.ts; r.ta = p.ta; r.tb = p.tb;
    if (paper_sel && !(p.ta < p.tb)) begin
      x1 = p.bx; y1 = p.by; x2 = p.ax; y2 = p.ay;
    end
    dx = x2 - x1;
    dy = y2 - y1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    twor = 2 * 64'(rad_q8);
    r4 = 4 * 64'(rad_q8) * 64'(rad_q8);
    if (!(dx == 0 && dy == 0) && !(paper_sel && dy == 0) && adx <= twor && ady <= twor) begin
      d2 = adx * adx + ady * ady;
      if (d2 <= r4) begin
        hq = root_floor((r4 - d2) << 16);
        dl = root_floor(d2 << 16);
        magx = (ady * hq + dl / 2) / dl;
        magy = (adx * hq + dl / 2) / dl;
        offx = dy < 0 ? -longint'(magx) : longint'(magx);
        offy = dx < 0 ? longint'(magy) : -longint'(magy);
        if (paper_sel && dy < 0) begin
          offx = -offx;
          offy = -offy;
        end
        sx = x1 + x2;
        sy = y1 + y2;
        r.c1x = halve_sat(sx + offx);
        r.c1y = halve_sat(sy + offy);
        r.c2x = halve_sat(sx - offx);
        r.c2y = halve_sat(sy - offy);
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // random pair, mostly within reach of the radius
  function automatic pair_t random_pair();
    pair_t p;
    longint span, dx, dy;
    int kind;
    span = 2 * longint'(rad_q8) + 1;
    kind = $urandom_range(0, 11);
    p.ax = $urandom;
    p.ay = $urandom;
    p.ta = tcc_pkg::TrackW'($urandom);
    p.tb = tcc_pkg::TrackW'($urandom);
    p.ts = $urandom;
    dx = longint'($urandom_range(0, 2 * span)) - span;
    dy = longint'($urandom_range(0, 2 * span)) - span;
    case (kind)
      0: begin
        p.bx = $urandom;
        p.by = $urandom;
      end
      1: begin
        dx = 0;
        dy = 0;
      end
      2: dy = 0;
      3: p.tb = p.ta;
      4: begin
        dx = ($urandom_range(0, 1) ? 2 : -2) * longint'(rad_q8);
        dy = 0;
        if ($urandom_range(0, 1)) begin
          dy = dx;
          dx = 0;
        end
      end
      5: begin
        p.ax = 32'h7fffffff - $urandom_range(0, 1024);
        p.ay = 32'h80000000 + $urandom_range(0, 1024);
      end
      default: ;
    endcase
    if (kind != 0) begin
      p.bx = tcc_pkg::CoordW'(p.ax + dx);
      p.by = tcc_pkg::CoordW'(p.ay + dy);
    end
    return p;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // one input transaction; returns at the falling edge after acceptance, or later while the sender idles
  task automatic send_pair(input pair_t p, input bit typed, input disks_t typed_res);
    disks_t exp_res;
    in_ch.valid <= 1'b1;
    in_ch.first_x <= p.ax;
    in_ch.first_y <= p.ay;
    in_ch.first_track <= p.ta;
    in_ch.second_x <= p.bx;
    in_ch.second_y <= p.by;
    in_ch.second_track <= p.tb;
    in_ch.time_stamp <= p.ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_res = typed ? typed_res : predict_disks(p);
    pending_disks = {pending_disks, exp_res};
    @(negedge clk);
    if ((idle_sel == 1 && roll(81)) || (idle_sel == 3 && roll(11))) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ((idle_sel == 1 && roll(81)) || (idle_sel == 3 && roll(11))) @(negedge clk);
    end
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(input tcc_pkg::cfg_reg_t idx,
                           input logic [tcc_pkg::RadW-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_disks.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == tcc_pkg::REG_RADIUS) rad_q8 = val;
    else paper_sel = val[0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !((idle_sel == 2 && roll(81)) || (idle_sel == 3 && roll(11)));
  end

  // result check
  always @(posedge clk) begin
    disks_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_disks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction, ts %h",
                                       out_ch.out_time_stamp);
      end else begin
        e = pending_disks.pop_front();
        if (out_ch.disks_found !== e.found || out_ch.center_one_x !== e.c1x ||
            out_ch.center_one_y !== e.c1y || out_ch.center_two_x !== e.c2x ||
            out_ch.center_two_y !== e.c2y || out_ch.out_time_stamp !== e.ts ||
            out_ch.out_first_track !== e.ta || out_ch.out_second_track !== e.tb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %b %h %h %h %h %h %h %h got %b %h %h %h %h %h %h %h",
                     e.found, e.c1x, e.c1y, e.c2x, e.c2y, e.ts, e.ta, e.tb,
                     out_ch.disks_found, out_ch.center_one_x, out_ch.center_one_y,
                     out_ch.center_two_x, out_ch.center_two_y, out_ch.out_time_stamp,
                     out_ch.out_first_track, out_ch.out_second_track);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    pair_t p;
    disks_t t;
    logic [tcc_pkg::RadW-1:0] rad_list [NumPhase];
    int per_phase;
    idle_sel = 0;
    rad_q8 = 20'd256;
    paper_sel = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.first_track = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.second_track = '0;
    in_ch.time_stamp = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = tcc_pkg::REG_RADIUS;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at the reset radius
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != paper_sel)
        write_reg(tcc_pkg::REG_PAPER_MODE, 20'(dir_rows[i].mode));
      p = '{dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].ta, dir_rows[i].bx,
            dir_rows[i].by, dir_rows[i].tb, dir_rows[i].ts};
      t = '{default: '0};
      t.ts = p.ts; t.ta = p.ta; t.tb = p.tb;
      if (dir_rows[i].chk == CHK_MIDPOINT) begin
        t.found = 1'b1;
        t.c1x = dir_rows[i].mx; t.c2x = dir_rows[i].mx;
        t.c1y = dir_rows[i].my; t.c2y = dir_rows[i].my;
      end
      send_pair(p, dir_rows[i].chk != CHK_PREDICT, t);
    end

    // random phases over several register settings
    rad_list = '{20'd256, 20'd1, 20'hfffff, 20'd0, 20'($urandom), 20'($urandom_range(2, 4096)),
                 20'd256, 20'hfffff};
    per_phase = NumRand / NumPhase;
    for (int ph = 0; ph < NumPhase; ph++) begin
      write_reg(tcc_pkg::REG_RADIUS, rad_list[ph]);
      write_reg(tcc_pkg::REG_PAPER_MODE, 20'(ph % 2));
      for (int n = 0; n < per_phase; n++) begin
        idle_sel = ((n / 50) + ph) % 4;
        send_pair(random_pair(), 1'b0, t);
      end
    end

    // drain
    in_ch.valid <= 1'b0;
    idle_sel = 0;
    while (pending_disks.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    if (mismatches == 0 && pending_disks.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
